/* hw/rtl/gdmc_pkg.sv */
// ----------------------------------------------------------------------------
// gdmc_pkg
// Shared types, field widths and key packing for the glyph cache.
// ----------------------------------------------------------------------------
package gdmc_pkg;

   localparam int ENTRIES_DEFAULT = 1024;

   localparam int KEY_W       = 64;
   localparam int CHAR_W      = 21;
   localparam int COLOR_W     = 24;
   localparam int BYTE_W      = 8;
   localparam int FONT_W      = 48;
   localparam int HANDLE_W    = 32;
   localparam int DIM_W       = 12;
   localparam int COUNT_OUT_W = 11;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_STORE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_INDEX,
      ST_EVAL,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;   // write entry, set valid
      logic clr_en;  // clear valid only
   } mem_ctl_type;

   // code point low, then fg bytes 7:0, 15:8, 23:16 and bg red from bit 32 up;
   // attributes folded in at bit 24, font handle folded in shifted down by 4
   function automatic logic [KEY_W-1:0] make_key(
      input logic [CHAR_W-1:0]  char_code,
      input logic [COLOR_W-1:0] fore_color,
      input logic [BYTE_W-1:0]  back_red,
      input logic [BYTE_W-1:0]  attributes,
      input logic [FONT_W-1:0]  font_id
   );
      logic [KEY_W-1:0] base;
      logic [KEY_W-1:0] attr_part;
      logic [KEY_W-1:0] font_part;
      base      = {back_red, fore_color[23:16], fore_color[15:8], fore_color[7:0],
                   11'd0, char_code};
      attr_part = {32'd0, attributes, 24'd0};
      font_part = {20'd0, font_id[FONT_W-1:4]};
      return base ^ attr_part ^ font_part;
   endfunction

endpackage

/* hw/rtl/gdmc_index.sv */
// ----------------------------------------------------------------------------
// gdmc_index
// Slot index from key: low bits for a power-of-two depth, otherwise the
// remainder taken 16 key bits per step by a reciprocal multiply.
// ----------------------------------------------------------------------------
module gdmc_index #(
   parameter int ENTRIES = gdmc_pkg::ENTRIES_DEFAULT,
   parameter int IW      = $clog2(ENTRIES)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start_idx,
   input  logic [gdmc_pkg::KEY_W-1:0] key,
   output logic                       done,
   output logic [IW-1:0]              idx
);
   import gdmc_pkg::*;

   localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

   generate
      if (IS_POW2) begin : g_pow2
         logic          done_ff;
         logic [IW-1:0] idx_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start_idx;
            end
         end

         always_ff @(posedge clock) begin
            if (start_idx) begin
               idx_ff <= key[IW-1:0];
            end
         end

         assign done = done_ff;
         assign idx  = idx_ff;
      end else begin : g_fold
         localparam int          CHUNK_W = 16;
         localparam int          STEPS   = KEY_W / CHUNK_W;
         localparam int          SW      = $clog2(STEPS);
         localparam int          XW      = IW + CHUNK_W;
         localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / ENTRIES);

         logic                 run_ff, run_in;
         logic                 phase_ff, phase_in;
         logic                 done_ff, done_in;
         logic [SW-1:0]        step_ff, step_in;
         logic [KEY_W-1:0]     shift_ff, shift_in;
         logic [XW-1:0]        x_ff, x_in;
         logic [CHUNK_W-1:0]   quo_ff, quo_in;
         logic [IW-1:0]        rem_ff, rem_in;
         logic [XW-1:0]        x_cur;
         logic [XW+31:0]       prod_x;
         logic [XW-1:0]        prod_q;
         logic [XW-1:0]        diff;
         logic [IW:0]          rem_wide;

         // rem = (rem * 2^16 + chunk) mod ENTRIES, top chunk first.
         // Phase 0 estimates the quotient low by at most one, phase 1
         // subtracts and corrects once.
         always_comb begin
            x_cur    = {rem_ff, shift_ff[KEY_W-1 -: CHUNK_W]};
            prod_x   = (XW+32)'(x_cur) * (XW+32)'(RECIP);
            prod_q   = XW'(quo_ff) * XW'(ENTRIES);
            diff     = x_ff - prod_q;
            rem_wide = diff[IW:0];
            run_in   = run_ff;
            phase_in = phase_ff;
            done_in  = 1'b0;
            step_in  = step_ff;
            shift_in = shift_ff;
            x_in     = x_ff;
            quo_in   = quo_ff;
            rem_in   = rem_ff;
            if (start_idx) begin
               run_in   = 1'b1;
               phase_in = 1'b0;
               step_in  = '0;
               shift_in = key;
               rem_in   = '0;
            end else if (run_ff && !phase_ff) begin
               x_in     = x_cur;
               quo_in   = prod_x[32 +: CHUNK_W];
               phase_in = 1'b1;
            end else if (run_ff) begin
               shift_in = shift_ff << CHUNK_W;
               if (rem_wide >= (IW+1)'(ENTRIES)) begin
                  rem_in = IW'(rem_wide - (IW+1)'(ENTRIES));
               end else begin
                  rem_in = rem_wide[IW-1:0];
               end
               phase_in = 1'b0;
               step_in  = step_ff + SW'(1);
               if (step_ff == SW'(STEPS - 1)) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff   <= 1'b0;
               phase_ff <= 1'b0;
               done_ff  <= 1'b0;
               step_ff  <= '0;
            end else begin
               run_ff   <= run_in;
               phase_ff <= phase_in;
               done_ff  <= done_in;
               step_ff  <= step_in;
            end
         end

         always_ff @(posedge clock) begin
            shift_ff <= shift_in;
            x_ff     <= x_in;
            quo_ff   <= quo_in;
            rem_ff   <= rem_in;
         end

         assign done = done_ff;
         assign idx  = rem_ff;
      end
   endgenerate

endmodule

/* hw/rtl/gdmc_store.sv */
// ----------------------------------------------------------------------------
// gdmc_store
// Entry memory and valid-bit memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module gdmc_store #(
   parameter int ENTRIES = gdmc_pkg::ENTRIES_DEFAULT,
   parameter int IW      = $clog2(ENTRIES)
) (
   input  logic                  clock,
   input  gdmc_pkg::mem_ctl_type ctl,
   input  logic [IW-1:0]         addr,
   input  gdmc_pkg::entry_type   wr_entry,
   output gdmc_pkg::entry_type   rd_entry,
   output logic                  rd_valid
);
   import gdmc_pkg::*;

   entry_type data_mem [ENTRIES];
   logic      valid_mem [ENTRIES];
   entry_type rd_entry_ff;
   logic      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         data_mem[addr] <= wr_entry;
      end
      if (ctl.rd_en) begin
         rd_entry_ff <= data_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         valid_mem[addr] <= 1'b1;
      end else if (ctl.clr_en) begin
         valid_mem[addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
         rd_valid_ff <= valid_mem[addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

/* hw/rtl/glyph_direct_mapped_cache.sv */
// ----------------------------------------------------------------------------
// glyph_direct_mapped_cache
// Direct-mapped glyph texture cache: lookup, store with eviction report, clear.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low; its single result shows
// on the rsp_ ports for one cycle with rsp_strobe and cannot be held off.
// Lookup and store hold busy through the index and evaluate states. When
// ENTRIES is a power of two the slot index is the low key bits; otherwise
// it is a remainder formed 16 key bits at a time by a reciprocal multiply.
// A clear sweeps the valid memory one entry a cycle; mode 3 leaves busy low.
// After reset the same sweep runs over every entry with busy high.
module glyph_direct_mapped_cache #(
   parameter int ENTRIES = gdmc_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_mode,
   input  logic [gdmc_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [gdmc_pkg::COLOR_W-1:0]     req_fore_color,
   input  logic [gdmc_pkg::BYTE_W-1:0]      req_back_red,
   input  logic [gdmc_pkg::BYTE_W-1:0]      req_attributes,
   input  logic [gdmc_pkg::FONT_W-1:0]      req_font_id,
   input  logic [gdmc_pkg::HANDLE_W-1:0]    req_handle,
   input  logic [gdmc_pkg::DIM_W-1:0]       req_glyph_width,
   input  logic [gdmc_pkg::DIM_W-1:0]       req_glyph_height,
   output logic                             rsp_strobe,
   output logic                             rsp_hit,
   output logic [gdmc_pkg::HANDLE_W-1:0]    rsp_hit_handle,
   output logic [gdmc_pkg::DIM_W-1:0]       rsp_hit_width,
   output logic [gdmc_pkg::DIM_W-1:0]       rsp_hit_height,
   output logic                             rsp_evicted,
   output logic [gdmc_pkg::HANDLE_W-1:0]    rsp_evicted_handle,
   output logic [gdmc_pkg::COUNT_OUT_W-1:0] rsp_used_count
);
   import gdmc_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   state_type            state_ff, state_in;
   logic [1:0]           mode_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [HANDLE_W-1:0]  handle_ff;
   logic [DIM_W-1:0]     width_ff;
   logic [DIM_W-1:0]     height_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [IW-1:0]        sweep_ff, sweep_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [HANDLE_W-1:0]  rsp_hit_handle_ff, rsp_hit_handle_in;
   logic [DIM_W-1:0]     rsp_hit_width_ff, rsp_hit_width_in;
   logic [DIM_W-1:0]     rsp_hit_height_ff, rsp_hit_height_in;
   logic                 rsp_evicted_ff, rsp_evicted_in;
   logic [HANDLE_W-1:0]  rsp_evicted_handle_ff, rsp_evicted_handle_in;
   logic [COUNT_OUT_W-1:0] rsp_used_count_ff, rsp_used_count_in;

   logic                 accept;
   logic [KEY_W-1:0]     req_key;
   logic                 idx_start;
   logic                 idx_done;
   logic [IW-1:0]        idx;
   logic                 sweep_last;

   mem_ctl_type          mem_ctl;
   logic [IW-1:0]        mem_addr;
   entry_type            wr_entry;
   entry_type            rd_entry;
   logic                 rd_valid;
   logic                 match;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign req_key    = make_key(req_char_code, req_fore_color, req_back_red,
                                req_attributes, req_font_id);
   assign idx_start  = accept && (req_mode == MODE_LOOKUP || req_mode == MODE_STORE);
   assign sweep_last = (sweep_ff == IW'(ENTRIES - 1));
   assign match      = rd_valid && (rd_entry.key == key_ff);

   assign wr_entry.key    = key_ff;
   assign wr_entry.handle = handle_ff;
   assign wr_entry.width  = width_ff;
   assign wr_entry.height = height_ff;

   gdmc_index #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .start_idx (idx_start),
      .key       (req_key),
      .done      (idx_done),
      .idx       (idx)
   );

   gdmc_store #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_store (
      .clock    (clock),
      .ctl      (mem_ctl),
      .addr     (mem_addr),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOOKUP || req_mode == MODE_STORE) begin
                  state_in = ST_INDEX;
               end else if (req_mode == MODE_CLEAR) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_INDEX: begin
            if (idx_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // outputs, memory control, counters
   always_comb begin
      mem_ctl               = '0;
      mem_addr              = idx;
      sweep_in              = sweep_ff;
      count_in              = count_ff;
      rsp_strobe_in         = 1'b0;
      rsp_hit_in            = 1'b0;
      rsp_hit_handle_in     = '0;
      rsp_hit_width_in      = '0;
      rsp_hit_height_in     = '0;
      rsp_evicted_in        = 1'b0;
      rsp_evicted_handle_in = '0;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_ctl.clr_en = 1'b1;
            mem_addr       = sweep_ff;
            sweep_in       = sweep_last ? '0 : IW'(sweep_ff + IW'(1));
            if (state_ff == ST_CLEAR && sweep_last) begin
               count_in      = '0;
               rsp_strobe_in = 1'b1;
            end
         end
         ST_IDLE: begin
            sweep_in = '0;
            // unused mode: report the count and nothing else
            if (accept && req_mode != MODE_LOOKUP && req_mode != MODE_STORE &&
                req_mode != MODE_CLEAR) begin
               rsp_strobe_in = 1'b1;
            end
         end
         ST_INDEX: begin
            mem_ctl.rd_en = idx_done;
         end
         ST_EVAL: begin
            rsp_strobe_in = 1'b1;
            if (mode_ff == MODE_LOOKUP) begin
               if (match) begin
                  rsp_hit_in        = 1'b1;
                  rsp_hit_handle_in = rd_entry.handle;
                  rsp_hit_width_in  = rd_entry.width;
                  rsp_hit_height_in = rd_entry.height;
               end
            end else if (handle_ff != '0) begin
               mem_ctl.wr_en = 1'b1;
               if (rd_valid) begin
                  rsp_evicted_in        = 1'b1;
                  rsp_evicted_handle_in = rd_entry.handle;
               end else begin
                  count_in = CW'(count_ff + CW'(1));
               end
            end
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
      rsp_used_count_in = COUNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         key_ff    <= req_key;
         handle_ff <= req_handle;
         width_ff  <= req_glyph_width;
         height_ff <= req_glyph_height;
      end
      if (rsp_strobe_in) begin
         rsp_hit_ff            <= rsp_hit_in;
         rsp_hit_handle_ff     <= rsp_hit_handle_in;
         rsp_hit_width_ff      <= rsp_hit_width_in;
         rsp_hit_height_ff     <= rsp_hit_height_in;
         rsp_evicted_ff        <= rsp_evicted_in;
         rsp_evicted_handle_ff <= rsp_evicted_handle_in;
         rsp_used_count_ff     <= rsp_used_count_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_hit_handle     = rsp_hit_handle_ff;
   assign rsp_hit_width      = rsp_hit_width_ff;
   assign rsp_hit_height     = rsp_hit_height_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_evicted_handle = rsp_evicted_handle_ff;
   assign rsp_used_count     = rsp_used_count_ff;

`ifndef ASSERT_OFF
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EVAL || state_ff == ST_CLEAR ||
                           (state_ff == ST_IDLE && start)))
      else $error("result beat without a finishing command");

   a_write_only_store: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (state_ff == ST_EVAL && mode_ff == MODE_STORE &&
                         handle_ff != '0))
      else $error("entry write outside a live store");

   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |=> (state_ff == ST_EVAL))
      else $error("entry read not followed by evaluation");
`endif

endmodule
